// ===== src/csv_field_splitter_macros.svh =====
// assertion macros shared by the csv field splitter modules
`ifndef CSV_FIELD_SPLITTER_MACROS_SVH
`define CSV_FIELD_SPLITTER_MACROS_SVH

// condition implies consequence in the same cycle
`define CSV_FS_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csv splitter check failed");

// condition implies consequence in the next cycle
`define CSV_FS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csv splitter check failed");

`endif

// ===== src/csv_fs_pkg.sv =====
// types and constants of the csv field splitter
package csv_fs_pkg;

  localparam logic [7:0] QUOTE_BYTE  = 8'h22;
  localparam logic [7:0] DELIM_RESET = 8'h2C;

  // one classified byte: first result plus a flag for the trailing empty field
  typedef struct packed {
    logic       has_char;
    logic [7:0] out_char;
    logic       field_end;
    logic       line_done;
    logic       extra;
  } cmd_t;

endpackage

// ===== src/csv_fs_if.sv =====
// channel interfaces of the csv field splitter
interface csv_fs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_end;
  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink (input valid, input text_byte, input line_end, output ready);
endinterface

interface csv_fs_out_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] out_char;
  logic       field_end;
  logic       line_done;
  modport source (output valid, output has_char, output out_char, output field_end,
                  output line_done, input ready);
  modport sink (input valid, input has_char, input out_char, input field_end,
                input line_done, output ready);
endinterface

interface csv_fs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/csv_fs_front.sv =====
// front end: accepts text bytes, tracks quoting and classifies each byte
module csv_fs_front
  import csv_fs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  csv_fs_in_if.sink    text_in,
  input  logic [7:0]   delimiter,
  input  logic         q_full,
  output logic         push,
  output cmd_t         cmd
);

  logic in_quotes, in_quotes_next;
  logic quote_pending, quote_pending_next;
  logic accept;
  logic is_quote, is_delim, last;
  logic iq_eff, doubled, has, ended;

  assign text_in.ready = !q_full;
  assign accept        = text_in.valid && text_in.ready;
  assign last          = text_in.line_end;
  assign is_quote      = (text_in.text_byte == QUOTE_BYTE);
  assign is_delim      = (text_in.text_byte == delimiter);

  always_comb begin
    doubled            = quote_pending && is_quote;
    iq_eff             = (quote_pending && !is_quote) ? 1'b0 : in_quotes;
    has                = 1'b0;
    ended              = 1'b0;
    in_quotes_next     = iq_eff;
    quote_pending_next = 1'b0;
    if (doubled) begin
      has = 1'b1;
    end else if (!iq_eff && is_delim) begin
      ended = 1'b1;
    end else if (is_quote) begin
      if (iq_eff) begin
        in_quotes_next     = 1'b0;
        quote_pending_next = !last;
        if (!last) in_quotes_next = 1'b1;
      end else begin
        in_quotes_next = 1'b1;
      end
    end else begin
      has = 1'b1;
    end
    if (last) begin
      in_quotes_next     = 1'b0;
      quote_pending_next = 1'b0;
    end
  end

  assign push          = accept && (has || ended || last);
  assign cmd.has_char  = has;
  assign cmd.out_char  = has ? text_in.text_byte : 8'h00;
  assign cmd.field_end = ended || last;
  assign cmd.extra     = last && is_delim;
  assign cmd.line_done = last && !is_delim;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes     <= 1'b0;
      quote_pending <= 1'b0;
    end else if (accept) begin
      in_quotes     <= in_quotes_next;
      quote_pending <= quote_pending_next;
    end
  end

endmodule

// ===== src/csv_fs_queue.sv =====
// short command queue between front and back end
`include "csv_field_splitter_macros.svh"
module csv_fs_queue
  import csv_fs_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t           mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `CSV_FS_ASSERT_NOW(a_no_overflow, clk, rst, push, !full || pop)
  `CSV_FS_ASSERT_NOW(a_no_underflow, clk, rst, pop, q_valid)
  `CSV_FS_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

// ===== src/csv_fs_back.sv =====
// back end: turns queued commands into results behind an output register
`include "csv_field_splitter_macros.svh"
module csv_fs_back
  import csv_fs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  output logic          pop,
  csv_fs_out_if.source  result_out
);

  logic       out_valid;
  logic       out_has;
  logic [7:0] out_char;
  logic       out_fend;
  logic       out_done;
  logic       extra_pending;
  logic       can_load;

  assign can_load = !out_valid || result_out.ready;
  assign pop      = can_load && !extra_pending && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      extra_pending <= 1'b0;
    end else if (can_load) begin
      if (extra_pending) begin
        out_valid     <= 1'b1;
        extra_pending <= 1'b0;
      end else begin
        out_valid     <= q_valid;
        extra_pending <= q_valid && q_cmd.extra;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (extra_pending) begin
        // trailing empty field after a line-final delimiter
        out_has  <= 1'b0;
        out_char <= 8'h00;
        out_fend <= 1'b1;
        out_done <= 1'b1;
      end else if (q_valid) begin
        out_has  <= q_cmd.has_char;
        out_char <= q_cmd.out_char;
        out_fend <= q_cmd.field_end;
        out_done <= q_cmd.line_done;
      end
    end
  end

  assign result_out.valid     = out_valid;
  assign result_out.has_char  = out_has;
  assign result_out.out_char  = out_char;
  assign result_out.field_end = out_fend;
  assign result_out.line_done = out_done;

  `CSV_FS_ASSERT_NOW(a_extra_behind_first, clk, rst, extra_pending, out_valid && !out_done)
  `CSV_FS_ASSERT_NEXT(a_extra_shape, clk, rst, extra_pending && result_out.ready,
                      out_valid && out_done && out_fend && !out_has)
  `CSV_FS_ASSERT_NOW(a_no_pop_while_extra, clk, rst, extra_pending, !pop)

endmodule

// ===== src/csv_field_splitter.sv =====
// Quoted CSV field splitter. Text bytes of one line arrive on text_in, one per
// transaction, line_end set on the final byte; results leave on result_out as
// field bytes (has_char, out_char) with field_end closing a field and line_done
// on the last result of the line. The delimiter register (comma after reset)
// is written through cfg only while no line is in flight; the user must keep
// to this, the block does not enforce it. Throughput is one byte per cycle
// while the queue is not full: the front end classifies a byte in the cycle
// it is accepted, and a queue of QUEUE_DEPTH commands lets front and back
// stall independently. Results go from the queue to the output register, which
// drains one per cycle while ready; a line-final delimiter yields two results.
module csv_field_splitter
  import csv_fs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  csv_fs_in_if.sink     text_in,
  csv_fs_out_if.source  result_out,
  csv_fs_cfg_if.sink    cfg
);

  logic [7:0] delimiter;
  logic       push;
  cmd_t       push_cmd;
  logic       q_full;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       pop;

  // configuration: single register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RESET;
    end else if (cfg.valid) begin
      delimiter <= cfg.data;
    end
  end

  // front end: quote tracking and byte classification
  csv_fs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .delimiter (delimiter),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // decoupling queue of classified bytes
  csv_fs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // back end: result sequencing and output register
  csv_fs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the csv field splitter
module testbench;
  import csv_fs_pkg::*;

  // cycles before the run is declared hung
  localparam int CYCLE_LIMIT = 400000;
  // cycles to let items that give no result leave the pipeline
  localparam int DRAIN_CYCLES = 8;
  // bytes per random phase
  localparam int PHASE_BYTES = 270;
  localparam int NUM_PHASES = 6;

  // one result transaction as the checker sees it
  typedef struct packed {
    logic       has_char;
    logic [7:0] out_char;
    logic       field_end;
    logic       line_done;
  } split_res_t;

  typedef enum logic {ROW_TEXT, ROW_CFG} row_kind_t;

  // one row of the directed table; n_typed < 0 means use the predictor
  typedef struct {
    row_kind_t  kind;
    logic [7:0] data;
    logic       last;
    int         n_typed;
    split_res_t r0;
    split_res_t r1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  csv_fs_in_if  text_if ();
  csv_fs_out_if res_if ();
  csv_fs_cfg_if cfg_if ();

  csv_field_splitter u_dut (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_if),
    .result_out(res_if),
    .cfg       (cfg_if)
  );

  // splitter state as the predictor tracks it
  logic [7:0] delim_reg;
  logic       in_quote;
  logic       quote_pend;

  split_res_t split_results_q[$];
  stim_row_t  directed_rows[$];
  logic [7:0] line_buf[$];

  int fail_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  // idling odds in percent per item (sender) and per cycle (receiver)
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result receiver: ready low in reset, then drops in random bursts
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(12);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // append helpers for the three queues
  function automatic void add_expected(input split_res_t r);
    split_results_q.insert(split_results_q.size(), r);
  endfunction

  function automatic void add_line_byte(input logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endfunction

  function automatic void add_row(input stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic split_res_t res_of(logic h, logic [7:0] c, logic f, logic d);
    split_res_t r;
    r.has_char  = h;
    r.out_char  = c;
    r.field_end = f;
    r.line_done = d;
    return r;
  endfunction

  // field splitting rules for one accepted byte; returns the number of results
  function automatic int predict_split(input logic [7:0] b, input logic last,
                                       output split_res_t r0, output split_res_t r1);
    logic has;
    logic ended;
    logic handled;
    int   n;
    has = 1'b0;
    ended = 1'b0;
    handled = 1'b0;
    n = 0;
    r0 = '0;
    r1 = '0;
    // a held quote inside quotes: doubled quote or end of quoting
    if (quote_pend) begin
      quote_pend = 1'b0;
      if (b == QUOTE_BYTE) begin
        has = 1'b1;
        handled = 1'b1;
      end else begin
        in_quote = 1'b0;
      end
    end
    if (!handled) begin
      if (!in_quote && b == delim_reg) begin
        ended = 1'b1;
      end else if (b == QUOTE_BYTE) begin
        if (in_quote) begin
          // a closing quote on the final byte needs no lookahead
          if (last) in_quote = 1'b0;
          else quote_pend = 1'b1;
        end else begin
          in_quote = 1'b1;
        end
      end else begin
        has = 1'b1;
      end
    end
    if (has || ended || last) begin
      r0 = res_of(has, has ? b : 8'h00, ended || last, last && b != delim_reg);
      n = 1;
    end
    if (last) begin
      // final byte equal to the delimiter adds an empty field
      if (b == delim_reg) begin
        r1 = res_of(1'b0, 8'h00, 1'b1, 1'b1);
        n = 2;
      end
      in_quote = 1'b0;
      quote_pend = 1'b0;
    end
    return n;
  endfunction

  // one text transaction, with an optional sender gap before it
  task automatic send_text(input logic [7:0] b, input logic last, input int n_typed,
                           input split_res_t t0, input split_res_t t1);
    split_res_t p0;
    split_res_t p1;
    int         n;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    text_if.valid <= 1'b1;
    text_if.text_byte <= b;
    text_if.line_end <= last;
    do @(posedge clk); while (!text_if.ready);
    bytes_sent++;
    n = predict_split(b, last, p0, p1);
    // typed rows replace the predicted results
    if (n_typed >= 0) begin
      n = n_typed;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) add_expected(p0);
    if (n > 1) add_expected(p1);
  endtask

  // stop sending and wait until every expected result is in
  task automatic wait_idle();
    text_if.valid <= 1'b0;
    while (split_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_delim(input logic [7:0] d);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= d;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    delim_reg = d;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    while (v == delim_reg || v == QUOTE_BYTE) v = 8'($urandom_range(255));
    return v;
  endfunction

  // random line: mostly well-formed fields, the rest raw noise
  task automatic build_line();
    int n_fields;
    int len;
    int pick;
    line_buf.delete();
    if ($urandom_range(99) < 80) begin
      n_fields = $urandom_range(1, 4);
      for (int f = 0; f < n_fields; f++) begin
        if (f > 0) add_line_byte(delim_reg);
        len = $urandom_range(0, 4);
        if ($urandom_range(1) == 0) begin
          for (int i = 0; i < len; i++) add_line_byte(plain_byte());
        end else begin
          // quoted field with doubled quotes and embedded delimiters
          add_line_byte(QUOTE_BYTE);
          for (int i = 0; i < len; i++) begin
            pick = $urandom_range(5);
            if (pick == 0) begin
              add_line_byte(QUOTE_BYTE);
              add_line_byte(QUOTE_BYTE);
            end else if (pick == 1) begin
              add_line_byte(delim_reg);
            end else begin
              add_line_byte(plain_byte());
            end
          end
          add_line_byte(QUOTE_BYTE);
        end
      end
      if ($urandom_range(99) < 20) add_line_byte(delim_reg);
      if (line_buf.size() == 0) add_line_byte(plain_byte());
    end else begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(3);
        if (pick == 0) add_line_byte(delim_reg);
        else if (pick == 1) add_line_byte(QUOTE_BYTE);
        else add_line_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  // result checker against the oldest expectation
  always @(posedge clk) begin
    split_res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (split_results_q.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        want = split_results_q.pop_front();
        check_field("has_char", 8'(want.has_char), 8'(res_if.has_char));
        check_field("out_char", want.out_char, res_if.out_char);
        check_field("field_end", 8'(want.field_end), 8'(res_if.field_end));
        check_field("line_done", 8'(want.line_done), 8'(res_if.line_done));
      end
    end
  end

  task automatic row_text(input logic [7:0] b, input logic last, input int n,
                          input split_res_t r0, input split_res_t r1);
    stim_row_t row;
    row.kind = ROW_TEXT;
    row.data = b;
    row.last = last;
    row.n_typed = n;
    row.r0 = r0;
    row.r1 = r1;
    add_row(row);
  endtask

  task automatic row_cfg(input logic [7:0] d);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.data = d;
    row.last = 1'b0;
    row.n_typed = 0;
    row.r0 = '0;
    row.r1 = '0;
    add_row(row);
  endtask

  initial begin
    split_res_t nul;
    split_res_t fend;
    split_res_t empty_last;
    logic [7:0] phase_delim [NUM_PHASES];
    int         phase_gap [NUM_PHASES];
    int         phase_stall [NUM_PHASES];
    int         phase_start;

    nul = '0;
    fend = res_of(1'b0, 8'h00, 1'b1, 1'b0);
    empty_last = res_of(1'b0, 8'h00, 1'b1, 1'b1);

    // sender inputs known from the start
    rst <= 1'b1;
    text_if.valid <= 1'b0;
    text_if.text_byte <= 8'h00;
    text_if.line_end <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= 8'h00;

    delim_reg = DELIM_RESET;
    in_quote = 1'b0;
    quote_pend = 1'b0;

    // line: plain byte, delimiter, quoted delimiter, doubled quote,
    // held quote closed by a plain byte, top byte value as the final byte
    row_text(8'h61, 1'b0, 1, res_of(1'b1, 8'h61, 1'b0, 1'b0), nul);
    row_text(8'h2C, 1'b0, 1, fend, nul);
    row_text(QUOTE_BYTE, 1'b0, 0, nul, nul);
    row_text(8'h2C, 1'b0, 1, res_of(1'b1, 8'h2C, 1'b0, 1'b0), nul);
    row_text(QUOTE_BYTE, 1'b0, -1, nul, nul);
    row_text(QUOTE_BYTE, 1'b0, -1, nul, nul);
    row_text(QUOTE_BYTE, 1'b0, -1, nul, nul);
    row_text(8'h62, 1'b0, -1, nul, nul);
    row_text(8'hFF, 1'b1, 1, res_of(1'b1, 8'hFF, 1'b1, 1'b1), nul);
    // quote as the final byte inside quotes is dropped
    row_text(QUOTE_BYTE, 1'b0, 0, nul, nul);
    row_text(QUOTE_BYTE, 1'b1, 1, empty_last, nul);
    // zero byte, then a final delimiter adds an empty field
    row_text(8'h00, 1'b0, 1, res_of(1'b1, 8'h00, 1'b0, 1'b0), nul);
    row_text(8'h2C, 1'b1, 2, fend, empty_last);
    // final delimiter inside quotes is a field byte and still adds a field
    row_text(QUOTE_BYTE, 1'b0, 0, nul, nul);
    row_text(8'h2C, 1'b1, 2, res_of(1'b1, 8'h2C, 1'b1, 1'b0), empty_last);
    // held quote followed by the delimiter ends quoting and the field
    row_text(QUOTE_BYTE, 1'b0, 0, nul, nul);
    row_text(8'h78, 1'b0, -1, nul, nul);
    row_text(QUOTE_BYTE, 1'b0, -1, nul, nul);
    row_text(8'h2C, 1'b0, 1, fend, nul);
    row_text(8'h80, 1'b1, 1, res_of(1'b1, 8'h80, 1'b1, 1'b1), nul);
    // delimiter equal to the quote byte
    row_cfg(QUOTE_BYTE);
    row_text(QUOTE_BYTE, 1'b0, 1, fend, nul);
    row_text(8'h71, 1'b1, 1, res_of(1'b1, 8'h71, 1'b1, 1'b1), nul);
    // zero delimiter
    row_cfg(8'h00);
    row_text(8'h00, 1'b1, 2, fend, empty_last);
    // top delimiter value
    row_cfg(8'hFF);
    row_text(8'h7A, 1'b0, -1, nul, nul);
    row_text(8'hFF, 1'b1, 2, fend, empty_last);

    phase_delim = '{8'h09, QUOTE_BYTE, 8'h00, 8'hFF, 8'h00, DELIM_RESET};
    phase_delim[4] = 8'($urandom_range(255));
    phase_gap = '{25, 0, 40, 10, 15, 0};
    phase_stall = '{25, 0, 10, 40, 30, 0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    gap_pct = 20;
    stall_pct = 20;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_delim(directed_rows[i].data);
      end else begin
        send_text(directed_rows[i].data, directed_rows[i].last,
                  directed_rows[i].n_typed, directed_rows[i].r0, directed_rows[i].r1);
      end
    end

    // random lines, one delimiter setting and idling profile per phase;
    // the last phase runs with no idling at all
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_delim(phase_delim[p]);
      gap_pct = phase_gap[p];
      stall_pct = phase_stall[p];
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        // now and then hold off until the output side has caught up
        if (p < NUM_PHASES - 1 && $urandom_range(49) == 0) wait_idle();
        build_line();
        foreach (line_buf[i]) begin
          send_text(line_buf[i], i == line_buf.size() - 1, -1, nul, nul);
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
